// File: sv/lapm_pkg.sv
// ----------------------------------------------------------------------------
// lapm_pkg
// Shared types and constants for the landing abort persistence monitor.
// ----------------------------------------------------------------------------
package lapm_pkg;

  typedef enum logic [2:0] {
    CMD_TARGET = 3'd0,
    CMD_NAV    = 3'd1,
    CMD_PATH   = 3'd2,
    CMD_GOTO   = 3'd3,
    CMD_LAND   = 3'd4,
    CMD_DYN    = 3'd5,
    CMD_TICK   = 3'd6
  } cmd_e_t;

  typedef enum logic [1:0] {
    RSN_NONE  = 2'd0,
    RSN_ALT   = 2'd1,
    RSN_CROSS = 2'd2,
    RSN_SLIP  = 2'd3
  } reason_t;

  localparam logic [1:0] CFG_ENABLED = 2'd0;
  localparam logic [1:0] CFG_VTOL    = 2'd1;
  localparam logic [1:0] CFG_HTOL    = 2'd2;
  localparam logic [1:0] CFG_STOL    = 2'd3;

  localparam int LEN_W   = 24;
  localparam int ANG_W   = 16;
  localparam int LTOL_W  = 11;
  localparam int ATOL_W  = 15;
  localparam int CFG_W   = 15;
  localparam int WP_W    = 8;
  localparam int IN_W    = 128;
  localparam int OUT_W   = 16;

  localparam int OFS_TGT    = 0;
  localparam int OFS_REF    = 24;
  localparam int OFS_DOWN   = 48;
  localparam int OFS_HDG    = 72;
  localparam int OFS_COURSE = 88;
  localparam int OFS_CROSS  = 104;

  localparam logic [WP_W-1:0] WP_ABORT = 8'd3;

  localparam logic [LTOL_W-1:0] VTOL_RST = 11'd256;
  localparam logic [LTOL_W-1:0] HTOL_RST = 11'd256;
  localparam logic [ATOL_W-1:0] STOL_RST = 15'd8192;

  typedef struct packed {
    logic eval;
    logic clear;
  } det_ctl_t;

endpackage

// File: sv/lapm_persist.sv
// ----------------------------------------------------------------------------
// lapm_persist
// One persistence detector: flags when the new magnitude and every stored
// magnitude are at or above the tolerance; history shifts on each eval.
// ----------------------------------------------------------------------------
module lapm_persist #(
  parameter int W     = 24,
  parameter int TOL_W = 11,
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lapm_pkg::det_ctl_t  ctl,
  input  logic [W-1:0]        cur,
  input  logic [TOL_W-1:0]    tol,
  output logic                flag_nxt,
  output logic                flag
);

  logic [W-1:0] hist_r [DEPTH];
  logic [W-1:0] tol_ext;
  logic         hit;
  logic         flag_r;

  assign tol_ext = {{(W-TOL_W){1'b0}}, tol};

  always_comb begin
    hit = (cur >= tol_ext);
    for (int i = 0; i < DEPTH; i++) begin
      if (hist_r[i] < tol_ext) begin
        hit = 1'b0;
      end
    end
  end

  always_comb begin
    flag_nxt = flag_r;
    if (ctl.clear) begin
      flag_nxt = 1'b0;
    end else if (ctl.eval) begin
      flag_nxt = hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      flag_r <= 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        hist_r[i] <= '0;
      end
    end else if (ctl.eval) begin
      flag_r    <= hit;
      hist_r[0] <= cur;
      for (int i = 1; i < DEPTH; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end
  end

  assign flag = flag_r;

endmodule

// File: sv/landing_abort_persistence_monitor.sv
// ----------------------------------------------------------------------------
// landing_abort_persistence_monitor
// Altitude, cross-track and sideslip persistence monitor with waypoint
// tracking; requests an evasive plan on a tick at the abort waypoint.
// ----------------------------------------------------------------------------
//  channel | dir | ports                          | payload
//  in      | in  | in_tvalid/in_tready            | tuser cmd, tdata 128 b
//  out     | out | out_tvalid/out_tready          | tdata 16 b
//  cfg     | in  | cfg_valid/cfg_ready            | cfg_addr, cfg_data
//
//  One beat per cycle sustained while out_tready is high; each input beat
//  passes the input register, then the result register, to its result beat.
//  Synchronous active-low reset clears control state and all detectors.
//  An output stall holds the result; the input register still takes one
//  beat while the result waits.
// ----------------------------------------------------------------------------
module landing_abort_persistence_monitor #(
  parameter int PERSIST_SAMPLES = 5
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [2:0] cmd
  input  logic [2:0]                  in_tuser,
  // [23:0] target_height, [47:24] ref_height, [71:48] down_position,
  // [87:72] heading, [103:88] course, [127:104] cross_track
  input  logic [lapm_pkg::IN_W-1:0]   in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [0] evasive, [2:1] reason, [10:3] waypoint_index, [13:11] error_flags
  output logic [lapm_pkg::OUT_W-1:0]  out_tdata,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_addr,
  input  logic [lapm_pkg::CFG_W-1:0]  cfg_data
);

  localparam int DEPTH = PERSIST_SAMPLES - 1;
  localparam int LW = lapm_pkg::LEN_W;
  localparam int AW = lapm_pkg::ANG_W;

  // config
  logic                          enabled_r;
  logic [lapm_pkg::LTOL_W-1:0]   vtol_r;
  logic [lapm_pkg::LTOL_W-1:0]   htol_r;
  logic [lapm_pkg::ATOL_W-1:0]   stol_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
      vtol_r    <= lapm_pkg::VTOL_RST;
      htol_r    <= lapm_pkg::HTOL_RST;
      stol_r    <= lapm_pkg::STOL_RST;
    end else if (cfg_valid) begin
      case (cfg_addr)
        lapm_pkg::CFG_ENABLED: enabled_r <= cfg_data[0];
        lapm_pkg::CFG_VTOL:    vtol_r    <= cfg_data[lapm_pkg::LTOL_W-1:0];
        lapm_pkg::CFG_HTOL:    htol_r    <= cfg_data[lapm_pkg::LTOL_W-1:0];
        lapm_pkg::CFG_STOL:    stol_r    <= cfg_data[lapm_pkg::ATOL_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                          s1_valid_r;
  lapm_pkg::cmd_e_t              s1_cmd_r;
  logic [lapm_pkg::IN_W-1:0]     s1_data_r;
  logic                          out_valid_r;
  logic [lapm_pkg::OUT_W-1:0]    out_data_r;
  logic                          proc;
  logic                          in_acc;

  assign proc      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || proc;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (proc) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r  <= lapm_pkg::cmd_e_t'(in_tuser);
      s1_data_r <= in_tdata;
    end
  end

  // field extraction
  logic [LW-1:0] f_tgt, f_ref, f_down, f_cross;
  logic [AW-1:0] f_hdg, f_course;

  assign f_tgt    = s1_data_r[lapm_pkg::OFS_TGT    +: LW];
  assign f_ref    = s1_data_r[lapm_pkg::OFS_REF    +: LW];
  assign f_down   = s1_data_r[lapm_pkg::OFS_DOWN   +: LW];
  assign f_hdg    = s1_data_r[lapm_pkg::OFS_HDG    +: AW];
  assign f_course = s1_data_r[lapm_pkg::OFS_COURSE +: AW];
  assign f_cross  = s1_data_r[lapm_pkg::OFS_CROSS  +: LW];

  // height state and magnitudes
  logic [LW-1:0] alt_r;
  logic [LW:0]   alt_err_w, alt_new_w;
  logic [LW-1:0] alt_err, alt_new;
  logic [LW-1:0] alt_mag, cross_mag;
  logic [AW-1:0] slip_diff, slip_mag;

  function automatic logic [LW-1:0] sat_len(input logic [LW:0] v);
    logic [LW-1:0] r;
    if (v[LW] != v[LW-1]) begin
      r = v[LW] ? {1'b1, {(LW-1){1'b0}}} : {1'b0, {(LW-1){1'b1}}};
    end else begin
      r = v[LW-1:0];
    end
    return r;
  endfunction

  assign alt_err_w = {f_tgt[LW-1], f_tgt} - {alt_r[LW-1], alt_r};
  assign alt_err   = sat_len(alt_err_w);
  assign alt_mag   = alt_err[LW-1] ? (~alt_err + 1'b1) : alt_err;
  assign alt_new_w = {f_ref[LW-1], f_ref} - {f_down[LW-1], f_down};
  assign alt_new   = sat_len(alt_new_w);
  assign slip_diff = f_course - f_hdg;
  assign slip_mag  = slip_diff[AW-1] ? (~slip_diff + 1'b1) : slip_diff;
  assign cross_mag = f_cross[LW-1] ? (~f_cross + 1'b1) : f_cross;

  logic is_tgt, is_nav, is_path, is_goto, is_land, is_dyn, is_tick;

  assign is_tgt  = proc && (s1_cmd_r == lapm_pkg::CMD_TARGET);
  assign is_nav  = proc && (s1_cmd_r == lapm_pkg::CMD_NAV);
  assign is_path = proc && (s1_cmd_r == lapm_pkg::CMD_PATH);
  assign is_goto = proc && (s1_cmd_r == lapm_pkg::CMD_GOTO);
  assign is_land = proc && (s1_cmd_r == lapm_pkg::CMD_LAND);
  assign is_dyn  = proc && (s1_cmd_r == lapm_pkg::CMD_DYN);
  assign is_tick = proc && (s1_cmd_r == lapm_pkg::CMD_TICK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alt_r <= '0;
    end else if (is_nav) begin
      alt_r <= alt_new;
    end
  end

  // detectors
  lapm_pkg::det_ctl_t alt_ctl, cross_ctl, slip_ctl;
  logic alt_flag_nxt, cross_flag_nxt, slip_flag_nxt;
  logic alt_flag, cross_flag, slip_flag;

  assign alt_ctl   = '{eval: is_tgt,  clear: is_land};
  assign cross_ctl = '{eval: is_path, clear: is_land};
  assign slip_ctl  = '{eval: is_nav,  clear: is_land};

  lapm_persist #(.W(LW), .TOL_W(lapm_pkg::LTOL_W), .DEPTH(DEPTH)) u_alt (
    .clk, .rst_n, .ctl(alt_ctl), .cur(alt_mag), .tol(vtol_r),
    .flag_nxt(alt_flag_nxt), .flag(alt_flag)
  );

  lapm_persist #(.W(LW), .TOL_W(lapm_pkg::LTOL_W), .DEPTH(DEPTH)) u_cross (
    .clk, .rst_n, .ctl(cross_ctl), .cur(cross_mag), .tol(htol_r),
    .flag_nxt(cross_flag_nxt), .flag(cross_flag)
  );

  lapm_persist #(.W(AW), .TOL_W(lapm_pkg::ATOL_W), .DEPTH(DEPTH)) u_slip (
    .clk, .rst_n, .ctl(slip_ctl), .cur(slip_mag), .tol(stol_r),
    .flag_nxt(slip_flag_nxt), .flag(slip_flag)
  );

  // waypoint tracking
  logic [lapm_pkg::WP_W-1:0] wp_r, wp_nxt;
  logic first_r, first_nxt, dyn_r, dyn_nxt;

  always_comb begin
    wp_nxt    = wp_r;
    first_nxt = first_r;
    dyn_nxt   = dyn_r;
    if (is_goto) begin
      if (first_r) begin
        wp_nxt    = '0;
        first_nxt = 1'b0;
      end else if (dyn_r) begin
        dyn_nxt = 1'b0;
        wp_nxt  = wp_r - 1'b1;
      end else begin
        wp_nxt = wp_r + 1'b1;
      end
    end
    if (is_land) begin
      wp_nxt    = '0;
      first_nxt = 1'b1;
    end
    if (is_dyn) begin
      dyn_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      first_r <= 1'b1;
      dyn_r   <= 1'b0;
    end else begin
      wp_r    <= wp_nxt;
      first_r <= first_nxt;
      dyn_r   <= dyn_nxt;
    end
  end

  // evasion decision
  lapm_pkg::reason_t reason;
  logic evasive;

  always_comb begin
    reason = lapm_pkg::RSN_NONE;
    if (is_tick && enabled_r && (wp_r == lapm_pkg::WP_ABORT)) begin
      if (alt_flag) begin
        reason = lapm_pkg::RSN_ALT;
      end else if (cross_flag) begin
        reason = lapm_pkg::RSN_CROSS;
      end else if (slip_flag) begin
        reason = lapm_pkg::RSN_SLIP;
      end
    end
  end

  assign evasive = (reason != lapm_pkg::RSN_NONE);

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_data_r <= {2'b00, slip_flag_nxt, cross_flag_nxt, alt_flag_nxt,
                     wp_nxt, reason, evasive};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  a_land_clears: assert property (@(posedge clk) disable iff (!rst_n)
    is_land |=> (out_tdata[13:3] == '0))
    else $error("land plan left flags or waypoint set");

  a_evasive_reason: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tdata[0]) |-> (out_tdata[2:1] != lapm_pkg::RSN_NONE))
    else $error("evasive without a reason");

  a_evasive_wp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tdata[0]) |-> (out_tdata[10:3] == lapm_pkg::WP_ABORT))
    else $error("evasive away from abort waypoint");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without a pending result");
`endif

endmodule
